/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hfl_pkg.sv */
// Shared types, constants and helper functions of the haptic force law.
`default_nettype none
package hfl_pkg;

    localparam int NUM_W      = 52;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 52;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_FEEDBACK = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] lin_vel_x;
        logic signed [31:0] lin_vel_y;
        logic signed [31:0] lin_vel_z;
        logic signed [31:0] ang_vel_x;
        logic signed [31:0] ang_vel_y;
        logic signed [31:0] ang_vel_z;
        logic signed [31:0] grip_vel;
        logic               button;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic signed [31:0] grip_force;
        logic               indexing;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_SPRING_GAIN       = 3'd0,
        CFG_SPRING_LIMIT      = 3'd1,
        CFG_ROT_DAMPING       = 3'd2,
        CFG_GRIPPER_VISCOSITY = 3'd3,
        CFG_MAX_FRICTION      = 3'd4,
        CFG_FRICTION_REGION   = 3'd5,
        CFG_MAX_FEEDBACK      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] spring_gain;
        logic [15:0] spring_limit;
        logic [19:0] rot_damping;
        logic [23:0] gripper_viscosity;
        logic [19:0] max_friction;
        logic [15:0] friction_region;
        logic [21:0] max_feedback;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        spring_gain:       24'd1769472,
        spring_limit:      16'd3277,
        rot_damping:       20'd2621,
        gripper_viscosity: 24'd1966080,
        max_friction:      20'd49152,
        friction_region:   16'd3277,
        max_feedback:      22'd655360
    };

    typedef enum logic [3:0] {
        MOP_SQ_X  = 4'd0,
        MOP_SQ_Y  = 4'd1,
        MOP_SQ_Z  = 4'd2,
        MOP_SPR_X = 4'd3,
        MOP_SPR_Y = 4'd4,
        MOP_SPR_Z = 4'd5,
        MOP_FRI_X = 4'd6,
        MOP_FRI_Y = 4'd7,
        MOP_FRI_Z = 4'd8,
        MOP_ANG_X = 4'd9,
        MOP_ANG_Y = 4'd10,
        MOP_ANG_Z = 4'd11,
        MOP_GRIP  = 4'd12
    } t_mop;

    localparam int MOP_LAST = 12;

    typedef struct packed {
        logic       accept;
        logic       mul_go;
        t_mop       mul_op;
        logic       root_init;
        logic       root_step;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic [1:0] axis;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    // Opposing term: negate the magnitude when the source is non-negative.
    function automatic logic [31:0] oppose(input logic src_neg, input logic [31:0] m);
        return src_neg ? m : (32'd0 - m);
    endfunction

endpackage
`default_nettype wire

/* rtl/hfl_regs.sv */
// Configuration register bank of the haptic force law.
`default_nettype none
module hfl_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output hfl_pkg::t_cfg     o_cfg
);
    import hfl_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPRING_GAIN:       n_cfg.spring_gain       = i_cfg_data[23:0];
                CFG_SPRING_LIMIT:      n_cfg.spring_limit      = i_cfg_data[15:0];
                CFG_ROT_DAMPING:       n_cfg.rot_damping       = i_cfg_data[19:0];
                CFG_GRIPPER_VISCOSITY: n_cfg.gripper_viscosity = i_cfg_data[23:0];
                CFG_MAX_FRICTION:      n_cfg.max_friction      = i_cfg_data[19:0];
                CFG_FRICTION_REGION:   n_cfg.friction_region   = i_cfg_data[15:0];
                CFG_MAX_FEEDBACK:      n_cfg.max_feedback      = i_cfg_data[21:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

/* rtl/hfl_ctrl.sv */
// Sequencer of the haptic force law: multiply, square root, divide, deliver.
`default_nettype none
`include "assert_macros.svh"
module hfl_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_is_feedback,
    input  hfl_pkg::t_sts i_sts,
    output hfl_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import hfl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ROOT = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        cmd     = '0;
        cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (!i_is_feedback) begin
                        n_state = S_MUL;
                        n_cnt   = 6'd0;
                    end
                end
            end
            S_MUL: begin
                if (r_cnt <= 6'(MOP_LAST)) begin
                    cmd.mul_go = 1'b1;
                    cmd.mul_op = t_mop'(r_cnt[3:0]);
                end
                if (r_cnt == 6'(MOP_LAST + 1)) begin
                    n_state = S_ROOT;
                    n_cnt   = 6'd0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ROOT: begin
                if (r_cnt == 6'd0) begin
                    cmd.root_init = 1'b1;
                end else begin
                    cmd.root_step = 1'b1;
                end
                if (r_cnt == 6'(ROOT_STEPS)) begin
                    n_state = S_DIV;
                    n_cnt   = 6'd0;
                    n_axis  = 2'd0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'd0) begin
                    cmd.div_load = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end else if (r_cnt == 6'(DIV_STEPS + 1)) begin
                    cmd.div_store = 1'b1;
                    n_cnt = 6'd0;
                    if (r_axis == 2'd2) begin
                        n_state = S_FIN;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 6'd0;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    `ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, cmd.accept && !i_is_feedback, r_state == S_MUL, "tick did not start the multiply phase")
    `ASSERT_HOLDS(a_load_free, i_clk, i_rst_n, !cmd.out_load || !i_sts.out_busy, "result loaded over a waiting beat")
    `ASSERT_NEXT(a_fin_done, i_clk, i_rst_n, cmd.out_load, r_state == S_IDLE, "sequencer did not return to idle")
endmodule
`default_nettype wire

/* rtl/hfl_dp.sv */
// Datapath of the haptic force law: shared multiplier, square root, divider, output beat.
`default_nettype none
`include "assert_macros.svh"
module hfl_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  hfl_pkg::t_cmd      i_cmd,
    input  hfl_pkg::t_cfg      i_cfg,
    input  hfl_pkg::t_in_item  i_in,
    input  wire logic          i_out_ready,
    output hfl_pkg::t_sts      o_sts,
    output hfl_pkg::t_out_item o_out,
    output logic               o_out_valid
);
    import hfl_pkg::*;

    t_in_item         r_in;
    logic             r_idx;
    logic [31:0]      r_fb [3];
    logic [63:0]      r_prod;
    t_mop             r_prod_op;
    logic             r_prod_vld;
    logic [63:0]      r_acc;
    logic [31:0]      r_spr [3];
    logic [NUM_W-1:0] r_num [3];
    logic [31:0]      r_tq [3];
    logic [31:0]      r_grip;
    logic [63:0]      r_rem, r_root, r_bit;
    logic [NUM_W-1:0] r_dnum;
    logic [31:0]      r_drem, r_den, r_quo;
    logic [31:0]      r_fric [3];
    t_out_item        r_out;
    logic             r_out_vld;

    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [31:0] ang [3];
    logic [31:0] apos [3];
    logic [31:0] avel [3];
    logic [31:0] mul_a, mul_b;
    logic [63:0] root_try;
    logic [32:0] div_try;
    logic [31:0] speed, den, fb_lim, fb_nlim;
    logic [31:0] fb_new [3];
    logic [31:0] force_sum [3];
    t_out_item   out_next;

    always_comb begin
        pos[0] = r_in.vec_x;     pos[1] = r_in.vec_y;     pos[2] = r_in.vec_z;
        vel[0] = r_in.lin_vel_x; vel[1] = r_in.lin_vel_y; vel[2] = r_in.lin_vel_z;
        ang[0] = r_in.ang_vel_x; ang[1] = r_in.ang_vel_y; ang[2] = r_in.ang_vel_z;
        for (int i = 0; i < 3; i++) begin
            avel[i] = abs32(vel[i]);
            apos[i] = (abs32(pos[i]) > {16'd0, i_cfg.spring_limit}) ?
                      {16'd0, i_cfg.spring_limit} : abs32(pos[i]);
        end
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (i_cmd.mul_op)
            MOP_SQ_X:  begin mul_a = avel[0]; mul_b = avel[0]; end
            MOP_SQ_Y:  begin mul_a = avel[1]; mul_b = avel[1]; end
            MOP_SQ_Z:  begin mul_a = avel[2]; mul_b = avel[2]; end
            MOP_SPR_X: begin mul_a = apos[0]; mul_b = {8'd0, i_cfg.spring_gain}; end
            MOP_SPR_Y: begin mul_a = apos[1]; mul_b = {8'd0, i_cfg.spring_gain}; end
            MOP_SPR_Z: begin mul_a = apos[2]; mul_b = {8'd0, i_cfg.spring_gain}; end
            MOP_FRI_X: begin mul_a = avel[0]; mul_b = {12'd0, i_cfg.max_friction}; end
            MOP_FRI_Y: begin mul_a = avel[1]; mul_b = {12'd0, i_cfg.max_friction}; end
            MOP_FRI_Z: begin mul_a = avel[2]; mul_b = {12'd0, i_cfg.max_friction}; end
            MOP_ANG_X: begin mul_a = abs32(ang[0]); mul_b = {12'd0, i_cfg.rot_damping}; end
            MOP_ANG_Y: begin mul_a = abs32(ang[1]); mul_b = {12'd0, i_cfg.rot_damping}; end
            MOP_ANG_Z: begin mul_a = abs32(ang[2]); mul_b = {12'd0, i_cfg.rot_damping}; end
            MOP_GRIP:  begin
                mul_a = abs32(r_in.grip_vel);
                mul_b = {8'd0, i_cfg.gripper_viscosity};
            end
            default:   begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end

    always_comb begin
        root_try = r_root | r_bit;
        div_try  = {r_drem, r_dnum[NUM_W-1]};
        speed    = r_root[31:0];
        den      = (speed <= {16'd0, i_cfg.friction_region}) ?
                   {16'd0, i_cfg.friction_region} : speed;
        fb_lim   = {10'd0, i_cfg.max_feedback};
        fb_nlim  = 32'd0 - fb_lim;
        fb_new[0] = i_in.vec_x;
        fb_new[1] = i_in.vec_y;
        fb_new[2] = i_in.vec_z;
        for (int i = 0; i < 3; i++) begin
            if ($signed(fb_new[i]) > $signed(fb_lim)) begin
                fb_new[i] = fb_lim;
            end else if ($signed(fb_new[i]) < $signed(fb_nlim)) begin
                fb_new[i] = fb_nlim;
            end
            force_sum[i] = oppose(pos[i][31], r_spr[i])
                         + ((speed != 32'd0) ? oppose(vel[i][31], r_fric[i]) : 32'd0)
                         + (r_in.button ? r_fb[i] : 32'd0);
        end
        out_next.force_x    = force_sum[0];
        out_next.force_y    = force_sum[1];
        out_next.force_z    = force_sum[2];
        out_next.torque_x   = oppose(ang[0][31], r_tq[0]);
        out_next.torque_y   = oppose(ang[1][31], r_tq[1]);
        out_next.torque_z   = oppose(ang[2][31], r_tq[2]);
        out_next.grip_force = oppose(r_in.grip_vel[31], r_grip);
        out_next.indexing   = r_in.button;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= 1'b0;
            r_fb[0]    <= 32'd0;
            r_fb[1]    <= 32'd0;
            r_fb[2]    <= 32'd0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_in.operation == OP_TICK) begin
                    r_idx <= i_in.button;
                end else if (r_idx) begin
                    r_fb[0] <= fb_new[0];
                    r_fb[1] <= fb_new[1];
                    r_fb[2] <= fb_new[2];
                end
            end
            r_prod_vld <= i_cmd.mul_go;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.operation == OP_TICK) begin
            r_in <= i_in;
        end
        r_prod    <= 64'(mul_a) * 64'(mul_b);
        r_prod_op <= i_cmd.mul_op;
        if (r_prod_vld) begin
            unique case (r_prod_op)
                MOP_SQ_X:  r_acc     <= r_prod;
                MOP_SQ_Y:  r_acc     <= r_acc + r_prod;
                MOP_SQ_Z:  r_acc     <= r_acc + r_prod;
                MOP_SPR_X: r_spr[0]  <= r_prod[47:16];
                MOP_SPR_Y: r_spr[1]  <= r_prod[47:16];
                MOP_SPR_Z: r_spr[2]  <= r_prod[47:16];
                MOP_FRI_X: r_num[0]  <= r_prod[NUM_W-1:0];
                MOP_FRI_Y: r_num[1]  <= r_prod[NUM_W-1:0];
                MOP_FRI_Z: r_num[2]  <= r_prod[NUM_W-1:0];
                MOP_ANG_X: r_tq[0]   <= r_prod[47:16];
                MOP_ANG_Y: r_tq[1]   <= r_prod[47:16];
                MOP_ANG_Z: r_tq[2]   <= r_prod[47:16];
                MOP_GRIP:  r_grip    <= r_prod[47:16];
                default:   r_grip    <= r_grip;
            endcase
        end
        if (i_cmd.root_init) begin
            r_rem  <= r_acc;
            r_root <= 64'd0;
            r_bit  <= 64'd1 << 62;
        end else if (i_cmd.root_step) begin
            if (r_rem >= root_try) begin
                r_rem  <= r_rem - root_try;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_load) begin
            r_dnum <= r_num[i_cmd.axis];
            r_drem <= 32'd0;
            r_quo  <= 32'd0;
            r_den  <= den;
        end else if (i_cmd.div_step) begin
            r_dnum <= r_dnum << 1;
            if (div_try >= {1'b0, r_den}) begin
                r_drem <= 32'(div_try - {1'b0, r_den});
                r_quo  <= {r_quo[30:0], 1'b1};
            end else begin
                r_drem <= div_try[31:0];
                r_quo  <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            r_fric[i_cmd.axis] <= r_quo;
        end
        if (i_cmd.out_load) begin
            r_out <= out_next;
        end
    end

    assign o_sts.out_busy = r_out_vld && !i_out_ready;
    assign o_out          = r_out;
    assign o_out_valid    = r_out_vld;

    `ASSERT_NEXT(a_out_shown, i_clk, i_rst_n, i_cmd.out_load, r_out_vld, "loaded result not shown")
    `ASSERT_NEXT(a_fb_ignored, i_clk, i_rst_n, i_cmd.accept && i_in.operation == OP_FEEDBACK && !r_idx, $stable(r_fb[0]) && $stable(r_fb[2]), "feedback stored without indexing")
    `ASSERT_HOLDS(a_root_bit, i_clk, i_rst_n, !i_cmd.root_step || $onehot0(r_bit), "square root bit lost its shape")
endmodule
`default_nettype wire

/* rtl/haptic_force_law.sv */
// Top level of the haptic force law.
`default_nettype none
// Haptic master force law in signed Q16.16. A tick beat returns one result beat:
// it passes through the single shared 32x32 multiplier (squares, spring,
// friction numerators, damping, gripper viscosity), then through the
// one-bit-per-cycle square root of the speed, then through the restoring
// divider that forms each friction axis in turn. A feedback beat returns
// nothing. A new beat is taken as soon as the sequencer is idle, even while
// the last result still waits on the output register.
// Configuration writes are always taken and must arrive while the block is idle.
module haptic_force_law (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  hfl_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output hfl_pkg::t_out_item o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import hfl_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    hfl_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hfl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_is_feedback (i_in.operation == OP_FEEDBACK),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_in_ready    (o_in_ready)
    );

    hfl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out       (o_out),
        .o_out_valid (o_out_valid)
    );
endmodule
`default_nettype wire
